@@ rtl/drhd_pkg.sv @@
package drhd_pkg;

	localparam int HEADER_W   = 32;
	localparam int CODE_W     = 3;
	localparam int NUM_SLOTS  = 10;
	// one field past the last slot: rate of an interleaved last channel
	localparam int NUM_FIELDS = NUM_SLOTS + 1;
	localparam int PAD_W      = NUM_FIELDS * CODE_W - HEADER_W;
	localparam int COUNT_W    = 7;
	localparam int TOTAL_W    = 9;
	localparam int RESULT_W   = NUM_SLOTS * COUNT_W + TOTAL_W;
	localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - RESULT_W;
	localparam int MAX_TOTAL  = 320;

	localparam logic [CODE_W-1:0] INTERLEAVE_CODE = 3'd7;

	typedef logic [CODE_W-1:0]                    code_t;
	typedef logic [COUNT_W-1:0]                   count_t;
	typedef logic [NUM_SLOTS-1:0][COUNT_W-1:0]    count_vec_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		count_vec_t         counts;
	} result_t;

	function automatic count_t rate_samples(input code_t code);
		count_t n;
		case (code)
			3'd0:    n = 7'd0;
			3'd1:    n = 7'd1;
			3'd2:    n = 7'd2;
			3'd3:    n = 7'd4;
			3'd4:    n = 7'd8;
			3'd5:    n = 7'd16;
			3'd6:    n = 7'd32;
			default: n = 7'd0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/drhd_decode.sv @@
module drhd_decode #(
	parameter int NUM_DDC = 10
) (
	input  logic [drhd_pkg::HEADER_W-1:0] header,
	output drhd_pkg::result_t             result
);
	import drhd_pkg::*;

	logic [NUM_FIELDS*CODE_W-1:0] padded;
	code_t                        field [NUM_FIELDS];
	logic [NUM_SLOTS-1:0]         partner;
	logic [TOTAL_W-1:0]           sum;

	assign padded = {{PAD_W{1'b0}}, header};

	always_comb begin
		for (int f = 0; f < NUM_FIELDS; f++) begin
			field[f] = padded[f*CODE_W +: CODE_W];
		end
	end

	// partner[d]: slot d is the zeroed second half of an interleaved pair
	always_comb begin
		partner[0] = 1'b0;
		for (int d = 0; d < NUM_SLOTS - 1; d++) begin
			partner[d+1] = (d < NUM_DDC) && !partner[d] && (field[d] == INTERLEAVE_CODE);
		end
	end

	always_comb begin
		sum = '0;
		for (int d = 0; d < NUM_SLOTS; d++) begin
			if (d >= NUM_DDC || partner[d]) begin
				result.counts[d] = '0;
			end else if (field[d] != INTERLEAVE_CODE) begin
				result.counts[d] = rate_samples(field[d]);
			end else begin
				result.counts[d] = rate_samples(field[d+1]) << 1;
			end
			sum = sum + TOTAL_W'(result.counts[d]);
		end
		result.total = sum;
	end

endmodule

@@ rtl/ddc_rate_header_decoder.sv @@
// channel   dir  payload
// s_*       in   tdata[31:0] header
// m_*       out  tdata[69:0] count_ddc0..9 (7 bits each), [78:70] total_samples
//
// Two register stages: header register, then decode into the result register.
// One header per cycle sustained while m_tready stays high; the decode is one pass of
// a short 10-slot pair chain plus a 10-input narrow add.
// arst_n clears both stage valids; payload registers are not reset.
// A stall on m_tready holds the result and backs up into s_tready within the
// same cycle once both stages are full.
module ddc_rate_header_decoder #(
	parameter int NUM_DDC = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [drhd_pkg::HEADER_W-1:0]  s_tdata,  // header
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [drhd_pkg::M_TDATA_W-1:0] m_tdata   // count_ddc0..count_ddc9, total_samples, pad
);
	import drhd_pkg::*;

	logic                valid_s1;
	logic [HEADER_W-1:0] header_s1;
	logic                valid_s2;
	result_t             result_s2;
	result_t             decoded;
	logic                adv_s2;
	logic                adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) header_s1 <= s_tdata;
		if (adv_s2 && valid_s1) result_s2 <= decoded;
	end

	drhd_decode #(.NUM_DDC(NUM_DDC)) u_decode (
		.header (header_s1),
		.result (decoded)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{M_PAD_W{1'b0}}, result_s2};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled without a full, blocked pipeline");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted transaction not held in header stage");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.total <= TOTAL_W'(MAX_TOTAL)))
		else $error("frame total out of range");

endmodule
